FILE: rtl/slx_pkg.sv
`default_nettype none

package slx_pkg;

  // Default widths of the number value and the character code
  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int CHAR_WIDTH_DEF   = 16;

  // Widest values the internal result word must carry
  localparam int CHAR_MAX   = 32;
  localparam int NUMBER_MAX = 64;
  localparam int LINE_W     = 24;
  localparam int COL_W      = 16;
  localparam int OFF_W      = 32;
  localparam int RES_MAX    = 3;

  localparam logic [LINE_W-1:0] LINE_SAT = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_SAT  = {COL_W{1'b1}};

  // Result kinds
  localparam logic RK_TEXT = 1'b0;
  localparam logic RK_END  = 1'b1;

  // Lexer modes
  localparam logic [3:0] M_SKIP    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_CSTAR   = 4'd3;
  localparam logic [3:0] M_NAME    = 4'd4;
  localparam logic [3:0] M_NUMBER  = 4'd5;
  localparam logic [3:0] M_MINUS   = 4'd6;
  localparam logic [3:0] M_COLON1  = 4'd7;
  localparam logic [3:0] M_COLON2  = 4'd8;
  localparam logic [3:0] M_BANG    = 4'd9;
  localparam logic [3:0] M_LESS    = 4'd10;
  localparam logic [3:0] M_GREATER = 4'd11;
  localparam logic [3:0] M_HASH    = 4'd12;
  localparam logic [3:0] M_SYMBOL  = 4'd13;
  localparam logic [3:0] M_STRING  = 4'd14;
  localparam logic [3:0] M_ESCAPE  = 4'd15;

  // Token kinds
  localparam logic [5:0] T_NAME    = 6'd0;
  localparam logic [5:0] T_NUMBER  = 6'd1;
  localparam logic [5:0] T_STRING  = 6'd2;
  localparam logic [5:0] T_SYMBOL  = 6'd3;
  localparam logic [5:0] T_SEMI    = 6'd4;
  localparam logic [5:0] T_ARROW   = 6'd5;
  localparam logic [5:0] T_MINUS   = 6'd6;
  localparam logic [5:0] T_ASSIGN  = 6'd7;
  localparam logic [5:0] T_GASSIGN = 6'd8;
  localparam logic [5:0] T_COLON   = 6'd9;
  localparam logic [5:0] T_LPAR    = 6'd10;
  localparam logic [5:0] T_RPAR    = 6'd11;
  localparam logic [5:0] T_LCURLY  = 6'd12;
  localparam logic [5:0] T_RCURLY  = 6'd13;
  localparam logic [5:0] T_LBRACK  = 6'd14;
  localparam logic [5:0] T_RBRACK  = 6'd15;
  localparam logic [5:0] T_COMMA   = 6'd16;
  localparam logic [5:0] T_DOT     = 6'd17;
  localparam logic [5:0] T_EQ      = 6'd18;
  localparam logic [5:0] T_PLUS    = 6'd19;
  localparam logic [5:0] T_AND     = 6'd20;
  localparam logic [5:0] T_OR      = 6'd21;
  localparam logic [5:0] T_MOD     = 6'd22;
  localparam logic [5:0] T_MUL     = 6'd23;
  localparam logic [5:0] T_DIV     = 6'd24;
  localparam logic [5:0] T_NE      = 6'd25;
  localparam logic [5:0] T_NOT     = 6'd26;
  localparam logic [5:0] T_ASMB    = 6'd27;
  localparam logic [5:0] T_LTEQ    = 6'd28;
  localparam logic [5:0] T_LT      = 6'd29;
  localparam logic [5:0] T_ASME    = 6'd30;
  localparam logic [5:0] T_GTEQ    = 6'd31;
  localparam logic [5:0] T_GT      = 6'd32;
  localparam logic [5:0] T_LIST    = 6'd33;
  localparam logic [5:0] T_EOF     = 6'd34;

  // One result word
  typedef struct packed {
    logic                  kind;
    logic [5:0]            tok;
    logic [CHAR_MAX-1:0]   txt;
    logic [NUMBER_MAX-1:0] val;
    logic [LINE_W-1:0]     line;
    logic [COL_W-1:0]      col;
    logic [OFF_W-1:0]      off;
  } res_t;

  // Single-character operator lookup; T_EOF when the character starts nothing
  function automatic logic [5:0] single_op(input logic [CHAR_MAX-1:0] c);
    logic [5:0] t;
    t = T_EOF;
    if (c == CHAR_MAX'(";")) t = T_SEMI;
    if (c == CHAR_MAX'("(")) t = T_LPAR;
    if (c == CHAR_MAX'(")")) t = T_RPAR;
    if (c == CHAR_MAX'("{")) t = T_LCURLY;
    if (c == CHAR_MAX'("}")) t = T_RCURLY;
    if (c == CHAR_MAX'("[")) t = T_LBRACK;
    if (c == CHAR_MAX'("]")) t = T_RBRACK;
    if (c == CHAR_MAX'(",")) t = T_COMMA;
    if (c == CHAR_MAX'(".")) t = T_DOT;
    if (c == CHAR_MAX'("=")) t = T_EQ;
    if (c == CHAR_MAX'("+")) t = T_PLUS;
    if (c == CHAR_MAX'("&")) t = T_AND;
    if (c == CHAR_MAX'("|")) t = T_OR;
    if (c == CHAR_MAX'("%")) t = T_MOD;
    if (c == CHAR_MAX'("*")) t = T_MUL;
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/slx_step.sv
`default_nettype none

module slx_step import slx_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
  parameter int CHAR_WIDTH   = CHAR_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [CHAR_WIDTH-1:0]   char_code,
  input  logic                    end_of_input,
  output res_t [RES_MAX-1:0]      res,
  output logic [1:0]              res_n
);

  localparam int AW = NUMBER_WIDTH + 4;
  localparam logic [AW-1:0] HALF = AW'(1) << (NUMBER_WIDTH - 1);

  logic [3:0]              mode, mode_next;
  logic [OFF_W-1:0]        off, off_next;
  logic [LINE_W-1:0]       line, line_next;
  logic [COL_W-1:0]        col, col_next;
  logic [OFF_W-1:0]        s_off, s_off_next;
  logic [LINE_W-1:0]       s_line, s_line_next;
  logic [COL_W-1:0]        s_col, s_col_next;
  logic [NUMBER_WIDTH-1:0] acc, acc_next;
  logic                    neg, neg_next;
  logic                    stopped, stopped_next;

  logic [CHAR_MAX-1:0]     c;
  logic                    dig, alpha, alnum;
  logic [NUMBER_WIDTH-1:0] dval, acc_add, nval;
  logic [AW-1:0]           sum, lim;
  logic                    st;
  logic [5:0]              op;

  function automatic res_t mk(input logic k, input logic [5:0] t,
                              input logic [CHAR_MAX-1:0] x,
                              input logic [NUMBER_MAX-1:0] v,
                              input logic [LINE_W-1:0] l, input logic [COL_W-1:0] cc,
                              input logic [OFF_W-1:0] o);
    res_t r;
    r.kind = k; r.tok = t; r.txt = x; r.val = v;
    r.line = l; r.col = cc; r.off = o;
    return r;
  endfunction

  // Classify the character
  assign c     = CHAR_MAX'(char_code);
  assign dig   = (c >= CHAR_MAX'("0")) && (c <= CHAR_MAX'("9"));
  assign alpha = ((c >= CHAR_MAX'("A")) && (c <= CHAR_MAX'("Z"))) ||
                 ((c >= CHAR_MAX'("a")) && (c <= CHAR_MAX'("z")));
  assign alnum = alpha || dig;
  assign dval  = NUMBER_WIDTH'(c[3:0]);
  assign op    = single_op(c);

  // Append a digit with saturation at the signed limit
  assign lim     = neg ? HALF : HALF - AW'(1);
  assign sum     = (AW'(acc) << 3) + (AW'(acc) << 1) + AW'(dval);
  assign acc_add = (sum > lim) ? lim[NUMBER_WIDTH-1:0] : sum[NUMBER_WIDTH-1:0];
  assign nval    = neg ? (NUMBER_WIDTH'(0) - acc) : acc;

  always_comb begin
    mode_next = mode; off_next = off; line_next = line; col_next = col;
    s_off_next = s_off; s_line_next = s_line; s_col_next = s_col;
    acc_next = acc; neg_next = neg; stopped_next = stopped;
    res = '0; res_n = 2'd0; st = 1'b0;
    if (!stopped) begin
      // Continue the pending token or mark a restart
      if (!end_of_input) begin
        unique case (mode)
          M_SLASH: begin
            if (c == CHAR_MAX'("*")) mode_next = M_COMMENT; else st = 1'b1;
          end
          M_COMMENT: begin
            if (c == CHAR_MAX'("*")) mode_next = M_CSTAR;
          end
          M_CSTAR: begin
            if (c == CHAR_MAX'("/")) mode_next = M_SKIP;
            else if (c != CHAR_MAX'("*")) mode_next = M_COMMENT;
          end
          M_NAME: begin
            if (alnum || c == CHAR_MAX'(":") || c == CHAR_MAX'("_")) begin
              res[res_n] = mk(RK_TEXT, T_NAME, c, '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
            end else st = 1'b1;
          end
          M_NUMBER: begin
            if (dig) begin
              acc_next = acc_add;
              res[res_n] = mk(RK_TEXT, T_NAME, c, '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
            end else st = 1'b1;
          end
          M_MINUS: begin
            if (c == CHAR_MAX'(">")) begin
              res[res_n] = mk(RK_END, T_ARROW, CHAR_MAX'("-"), '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SKIP;
            end else if (dig) begin
              acc_next = dval; neg_next = 1'b1;
              res[0] = mk(RK_TEXT, T_NAME, CHAR_MAX'("-"), '0, s_line, s_col, s_off);
              res[1] = mk(RK_TEXT, T_NAME, c, '0, s_line, s_col, s_off);
              res_n = 2'd2;
              mode_next = M_NUMBER;
            end else st = 1'b1;
          end
          M_COLON1: begin
            if (c == CHAR_MAX'("=")) begin
              res[res_n] = mk(RK_END, T_ASSIGN, CHAR_MAX'(":"), '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SKIP;
            end else if (c == CHAR_MAX'(":")) mode_next = M_COLON2;
            else st = 1'b1;
          end
          M_COLON2: begin
            if (c == CHAR_MAX'("=")) begin
              res[res_n] = mk(RK_END, T_GASSIGN, CHAR_MAX'(":"), '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SKIP;
            end else st = 1'b1;
          end
          M_BANG: begin
            if (c == CHAR_MAX'("=")) begin
              res[res_n] = mk(RK_END, T_NE, CHAR_MAX'("!"), '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SKIP;
            end else st = 1'b1;
          end
          M_LESS: begin
            if (c == CHAR_MAX'("<") || c == CHAR_MAX'("=")) begin
              res[res_n] = mk(RK_END, (c == CHAR_MAX'("<")) ? T_ASMB : T_LTEQ,
                              CHAR_MAX'("<"), '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SKIP;
            end else st = 1'b1;
          end
          M_GREATER: begin
            if (c == CHAR_MAX'(">") || c == CHAR_MAX'("=")) begin
              res[res_n] = mk(RK_END, (c == CHAR_MAX'(">")) ? T_ASME : T_GTEQ,
                              CHAR_MAX'(">"), '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SKIP;
            end else st = 1'b1;
          end
          M_HASH: begin
            if (c == CHAR_MAX'("(")) begin
              res[res_n] = mk(RK_END, T_LIST, CHAR_MAX'("#"), '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SKIP;
            end else if (alnum) begin
              res[res_n] = mk(RK_TEXT, T_NAME, c, '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SYMBOL;
            end else st = 1'b1;
          end
          M_SYMBOL: begin
            if (alnum) begin
              res[res_n] = mk(RK_TEXT, T_NAME, c, '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
            end else st = 1'b1;
          end
          M_STRING: begin
            if (c == CHAR_MAX'("\\")) mode_next = M_ESCAPE;
            else if (c == CHAR_MAX'("'")) begin
              res[res_n] = mk(RK_END, T_STRING, '0, '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
              mode_next = M_SKIP;
            end else begin
              res[res_n] = mk(RK_TEXT, T_NAME, c, '0, s_line, s_col, s_off);
              res_n = res_n + 2'd1;
            end
          end
          M_ESCAPE: begin
            res[res_n] = mk(RK_TEXT, T_NAME, c, '0, s_line, s_col, s_off);
            res_n = res_n + 2'd1;
            mode_next = M_STRING;
          end
          default: st = 1'b1;
        endcase
      end

      // End the pending token before a restart or end of input
      if (st || end_of_input) begin
        mode_next = M_SKIP;
        unique case (mode)
          M_SLASH:   begin res[res_n] = mk(RK_END, T_DIV, CHAR_MAX'("/"), '0,
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_NAME:    begin res[res_n] = mk(RK_END, T_NAME, '0, '0,
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_NUMBER:  begin res[res_n] = mk(RK_END, T_NUMBER, '0, NUMBER_MAX'(nval),
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_MINUS:   begin res[res_n] = mk(RK_END, T_MINUS, CHAR_MAX'("-"), '0,
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_COLON1:  begin res[res_n] = mk(RK_END, T_COLON, CHAR_MAX'(":"), '0,
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_COLON2:  begin res[res_n] = mk(RK_END, T_GASSIGN, CHAR_MAX'(":"), '0,
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_BANG:    begin res[res_n] = mk(RK_END, T_NOT, CHAR_MAX'("!"), '0,
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_LESS:    begin res[res_n] = mk(RK_END, T_LT, CHAR_MAX'("<"), '0,
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_GREATER: begin res[res_n] = mk(RK_END, T_GT, CHAR_MAX'(">"), '0,
                                           s_line, s_col, s_off); res_n = res_n + 2'd1; end
          M_HASH, M_SYMBOL: begin
            res[res_n] = mk(RK_END, T_SYMBOL, '0, '0, s_line, s_col, s_off);
            res_n = res_n + 2'd1;
          end
          M_STRING, M_ESCAPE: begin
            res[res_n] = mk(RK_END, T_STRING, '0, '0, s_line, s_col, s_off);
            res_n = res_n + 2'd1;
          end
          default: ;
        endcase
        // Latch the new token start
        s_off_next = off; s_line_next = line; s_col_next = col;
      end

      if (end_of_input) begin
        res[res_n] = mk(RK_END, T_EOF, '0, '0, line, col, off);
        res_n = res_n + 2'd1;
        stopped_next = 1'b1;
      end else begin
        // Start a new token
        if (st) begin
          if (alpha) begin
            res[res_n] = mk(RK_TEXT, T_NAME, c, '0, line, col, off);
            res_n = res_n + 2'd1;
            mode_next = M_NAME;
          end else if (dig) begin
            acc_next = dval; neg_next = 1'b0;
            res[res_n] = mk(RK_TEXT, T_NAME, c, '0, line, col, off);
            res_n = res_n + 2'd1;
            mode_next = M_NUMBER;
          end else if (c == CHAR_MAX'("/")) mode_next = M_SLASH;
          else if (c == CHAR_MAX'("-")) mode_next = M_MINUS;
          else if (c == CHAR_MAX'(":")) mode_next = M_COLON1;
          else if (c == CHAR_MAX'("!")) mode_next = M_BANG;
          else if (c == CHAR_MAX'("<")) mode_next = M_LESS;
          else if (c == CHAR_MAX'(">")) mode_next = M_GREATER;
          else if (c == CHAR_MAX'("#")) mode_next = M_HASH;
          else if (c == CHAR_MAX'("'")) mode_next = M_STRING;
          else if (c == CHAR_MAX'(" ") || (c >= CHAR_MAX'(9) && c <= CHAR_MAX'(13))) begin
            mode_next = M_SKIP;
          end else begin
            res[res_n] = mk(RK_END, op, (op == T_EOF) ? '0 : c, '0, line, col, off);
            res_n = res_n + 2'd1;
            if (op == T_EOF) stopped_next = 1'b1;
          end
        end
        // Advance the position
        off_next = off + OFF_W'(1);
        if (c == CHAR_MAX'(10)) begin
          if (line != LINE_SAT) line_next = line + LINE_W'(1);
          col_next = COL_W'(1);
        end else if (col != COL_SAT) begin
          col_next = col + COL_W'(1);
        end
      end
    end
  end

  // Hold state between accepted words
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_SKIP; off <= '0; line <= LINE_W'(1); col <= COL_W'(1);
      s_off <= '0; s_line <= LINE_W'(1); s_col <= COL_W'(1);
      acc <= '0; neg <= 1'b0; stopped <= 1'b0;
    end else if (take) begin
      mode <= mode_next; off <= off_next; line <= line_next; col <= col_next;
      s_off <= s_off_next; s_line <= s_line_next; s_col <= s_col_next;
      acc <= acc_next; neg <= neg_next; stopped <= stopped_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slx_outq.sv
`default_nettype none

module slx_outq import slx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  res_t [RES_MAX-1:0] res,
  input  logic [1:0]         res_n,
  input  logic               pop,
  output logic               can_load,
  output logic [1:0]         pending,
  output res_t               head
);

  res_t [RES_MAX-1:0] buffer;
  logic [1:0]         rd;

  // Take a new group when the last held word leaves now or nothing is held
  assign can_load = (pending == 2'd0) || ((pending == 2'd1) && pop);
  assign head     = buffer[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      rd      <= 2'd0;
    end else if (load) begin
      pending <= res_n;
      rd      <= 2'd0;
    end else if (pop) begin
      pending <= pending - 2'd1;
      rd      <= rd + 2'd1;
    end
  end

  // Hold the payload of the group
  always_ff @(posedge clk) begin
    if (load) buffer <= res;
  end

endmodule

`default_nettype wire

FILE: rtl/script_lexer_unit.sv
// Streaming lexer: one source character per input word.
// Input channel: in_valid/in_ready with char_code and end_of_input.
// Output channel: out_valid/out_ready with one result word per transfer:
// a text character of a name, number, string or symbol, or a token record
// with its kind, value and start position. last marks the final word that
// one input word caused; an input word causes zero to two result words.
// Latency: results of a character appear the cycle after it is accepted.
// Throughput: one character per cycle while each causes at most one word and
// the receiver takes each word; a character causing more words holds off the
// next one while the single result port drains the three-entry result buffer.
// A new character is taken in the same cycle the last buffered word leaves.
// Reset clears position (line 1, column 1, offset 0), mode and stop flag.
// While the receiver stalls, words hold and in_ready drops once a group waits.
// End of input or an unknown character emits an end token and stops the
// block; later characters are accepted and dropped until reset.
`default_nettype none

module script_lexer_unit import slx_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
  parameter int CHAR_WIDTH   = CHAR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [CHAR_WIDTH-1:0]          char_code,
  input  logic                           end_of_input,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           result_kind,
  output logic [5:0]                     token_kind,
  output logic [CHAR_WIDTH-1:0]          text_char,
  output logic signed [NUMBER_WIDTH-1:0] number_value,
  output logic [LINE_W-1:0]              start_line,
  output logic [COL_W-1:0]               start_column,
  output logic [OFF_W-1:0]               start_offset,
  output logic                           last
);

  res_t [RES_MAX-1:0] res;
  logic [1:0]         res_n, pending;
  logic               accept, pop;
  res_t               head;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  slx_step #(.NUMBER_WIDTH(NUMBER_WIDTH), .CHAR_WIDTH(CHAR_WIDTH)) u_step (
    .clk(clk), .rst(rst), .take(accept), .char_code(char_code),
    .end_of_input(end_of_input), .res(res), .res_n(res_n)
  );

  slx_outq u_outq (
    .clk(clk), .rst(rst), .load(accept), .res(res), .res_n(res_n), .pop(pop),
    .can_load(in_ready), .pending(pending), .head(head)
  );

  // Drive the result word
  assign out_valid    = (pending != 2'd0);
  assign last         = (pending == 2'd1);
  assign result_kind  = head.kind;
  assign token_kind   = head.tok;
  assign text_char    = head.txt[CHAR_WIDTH-1:0];
  assign number_value = head.val[NUMBER_WIDTH-1:0];
  assign start_line   = head.line;
  assign start_column = head.col;
  assign start_offset = head.off;

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> pending == $past(res_n))
    else $error("result count not loaded");

  a_group_whole: assert property (@(posedge clk) disable iff (rst)
    pop && !last |=> out_valid)
    else $error("result group cut short");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |-> !in_ready)
    else $error("input taken over waiting results");

endmodule

`default_nettype wire
